// File: hw/rtl/pidc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the clamped positional PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;               // measured, target, drive (Q8.8)
    localparam int GAIN_W    = 16;               // signed Q8.8 gains
    localparam int LIMIT_W   = 15;               // unsigned Q7.8 clamp magnitudes
    localparam int ERR_W     = SAMPLE_W + 1;     // target - measured
    localparam int DERR_W    = ERR_W + 1;        // error - previous error
    localparam int FRAC_W    = 8;                // fraction bits dropped on output
    localparam int PROD_W    = GAIN_W + ERR_W;   // gain * error, Q17.16
    localparam int DPROD_W   = GAIN_W + DERR_W;  // gain * error delta, Q18.16
    localparam int INTEG_W   = 25;               // clamped integral, Q9.16
    localparam int IACC_W    = PROD_W + 1;       // integral + increment
    localparam int PD_W      = DPROD_W + 1;      // proportional + derivative
    localparam int SUM_W     = PD_W + 1;         // full unclamped sum

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PROP_GAIN   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_INTEG_GAIN  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_DERIV_GAIN  = cfg_idx_t'(2);
    localparam cfg_idx_t REG_INTEG_LIMIT = cfg_idx_t'(3);
    localparam cfg_idx_t REG_OUT_LIMIT   = cfg_idx_t'(4);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic        [LIMIT_W-1:0]  limit_t;
    typedef logic signed [ERR_W-1:0]    err_t;
    typedef logic signed [DERR_W-1:0]   derr_t;

    // Controller settings
    typedef struct packed {
        gain_t  prop_gain;
        gain_t  integ_gain;
        gain_t  deriv_gain;
        limit_t integ_limit;
        limit_t out_limit;
    } cfg_t;

    // One sample's error and error delta, as queued for the back end
    typedef struct packed {
        err_t  err;
        derr_t derr;
    } queue_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/pidc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_front
// Accepts sample beats, forms the error and its change since the last
// sample, and pushes both into the queue.
// ----------------------------------------------------------------------------
module pidc_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pidc_pkg::sample_t     s_measured,
    input  wire pidc_pkg::sample_t     s_target,
    input  wire pidc_pkg::queue_stat_t q_stat,
    output logic                       push,
    output pidc_pkg::queue_entry_t     push_entry
);
    import pidc_pkg::*;

    err_t prev_error_reg;
    err_t err;

    // accept whenever the queue has room
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // error and its delta, both exact
    assign err             = ERR_W'(s_target) - ERR_W'(s_measured);
    assign push_entry.err  = err;
    assign push_entry.derr = DERR_W'(err) - DERR_W'(prev_error_reg);

    // previous error tracks the last accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
        end else if (push) begin
            prev_error_reg <= err;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pidc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_queue
// Short FIFO between the front and the back, so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module pidc_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire pidc_pkg::queue_entry_t push_entry,
    input  wire logic                   pop,
    output pidc_pkg::queue_entry_t      pop_entry,
    output pidc_pkg::queue_stat_t       q_stat
);
    import pidc_pkg::*;

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_entry    = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pidc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_back
// Three-stage execution pipeline: gain products, integral update with its
// clamp, then the final sum with output clamp and Q8.8 conversion.
// ----------------------------------------------------------------------------
module pidc_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire pidc_pkg::cfg_t         cfg,
    input  wire pidc_pkg::queue_stat_t  q_stat,
    input  wire pidc_pkg::queue_entry_t pop_entry,
    output logic                        pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output pidc_pkg::sample_t           m_drive,
    output logic                        m_saturated
);
    import pidc_pkg::*;

    logic advance;

    // stage 1: products
    logic                      v1_reg;
    logic signed [PROD_W-1:0]  p_reg, p_next;
    logic signed [PROD_W-1:0]  i_reg, i_next;
    logic signed [DPROD_W-1:0] d_reg, d_next;

    // stage 2: integral state and P+D
    logic                      v2_reg;
    logic signed [INTEG_W-1:0] integ_sum_reg, integ_sum_next;
    logic signed [PD_W-1:0]    pd_reg, pd_next;
    logic signed [IACC_W-1:0]  iacc;
    logic signed [IACC_W-1:0]  ilim;
    logic signed [IACC_W-1:0]  iclamp;

    // stage 3: output register
    logic                      m_valid_reg;
    sample_t                   m_drive_reg, m_drive_next;
    logic                      m_saturated_reg, m_saturated_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   olim;
    logic signed [SUM_W-1:0]   oclamp;

    // whole pipeline moves unless the output beat is held
    assign advance = !m_valid_reg || m_ready;
    assign pop     = !q_stat.empty && advance;

    assign m_valid     = m_valid_reg;
    assign m_drive     = m_drive_reg;
    assign m_saturated = m_saturated_reg;

    // gain products, exact in Q17.16 (P, I) and Q18.16 (D)
    always_comb begin
        p_next = PROD_W'(cfg.prop_gain) * PROD_W'(pop_entry.err);
        i_next = PROD_W'(cfg.integ_gain) * PROD_W'(pop_entry.err);
        d_next = DPROD_W'(cfg.deriv_gain) * DPROD_W'(pop_entry.derr);
    end

    // integral accumulate and symmetric clamp; equal to limit passes
    always_comb begin
        ilim = $signed({{(IACC_W-LIMIT_W-FRAC_W){1'b0}}, cfg.integ_limit, {FRAC_W{1'b0}}});
        iacc = IACC_W'(integ_sum_reg) + IACC_W'(i_reg);
        if (iacc > ilim) begin
            iclamp = ilim;
        end else if (iacc < -ilim) begin
            iclamp = -ilim;
        end else begin
            iclamp = iacc;
        end
        integ_sum_next = iclamp[INTEG_W-1:0];
        pd_next        = PD_W'(p_reg) + PD_W'(d_reg);
    end

    // final sum, output clamp, floor to Q8.8
    always_comb begin
        olim = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, cfg.out_limit, {FRAC_W{1'b0}}});
        sum  = SUM_W'(pd_reg) + SUM_W'(integ_sum_reg);
        m_saturated_next = 1'b1;
        if (sum > olim) begin
            oclamp = olim;
        end else if (sum < -olim) begin
            oclamp = -olim;
        end else begin
            oclamp           = sum;
            m_saturated_next = 1'b0;
        end
        // clamped value fits LIMIT_W+FRAC_W+1 bits, so the slice is a floor shift
        m_drive_next = oclamp[SAMPLE_W+FRAC_W-1:FRAC_W];
    end

    // control and integral state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            integ_sum_reg <= '0;
        end else if (advance) begin
            v1_reg      <= pop;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
            if (v1_reg) begin
                integ_sum_reg <= integ_sum_next;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pop) begin
                p_reg <= p_next;
                i_reg <= i_next;
                d_reg <= d_next;
            end
            if (v1_reg) begin
                pd_reg <= pd_next;
            end
            if (v2_reg) begin
                m_drive_reg     <= m_drive_next;
                m_saturated_reg <= m_saturated_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pid_controller_clamped.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Clamped positional PID controller, signed Q8.8 in and out.
//
// Sample beats (s_measured, s_target) enter on the s_ valid/ready channel;
// each yields exactly one result beat (m_drive, m_saturated) on the m_
// channel, in order. Gains and clamp limits are written on the cfg_ channel
// (cfg_index 0..4: prop_gain, integ_gain, deriv_gain, integ_limit,
// out_limit; other indexes are dropped). The user must write them only
// while no sample is in flight; the block itself does not enforce this.
// cfg_ready is always high. A sample beat passes the queue, product stage,
// integral stage and output register before its result is valid.
// Throughput: one sample per cycle unless the receiver stalls; the integral
// add-and-clamp is combinational, and each gain uses its own multiplier.
// Reset clears gains, limits, the previous error and the integral to 0.
// When the receiver stalls, the back pipeline freezes with the result held;
// the two-entry queue keeps taking samples until full, then s_ready drops.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pidc_pkg::sample_t     s_measured,
    input  wire pidc_pkg::sample_t     s_target,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pidc_pkg::sample_t          m_drive,
    output logic                       m_saturated,
    // configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire pidc_pkg::cfg_idx_t    cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pidc_pkg::*;

    cfg_t         cfg_reg;
    queue_stat_t  q_stat;
    queue_entry_t push_entry;
    queue_entry_t pop_entry;
    logic         push;
    logic         pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_data[LIMIT_W-1:0];
                REG_OUT_LIMIT:   cfg_reg.out_limit   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    pidc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_target   (s_target),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    pidc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    pidc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive     (m_drive),
        .m_saturated (m_saturated)
    );

    // an accepted beat is in the queue on the next cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !q_stat.empty)
        else $error("accepted sample did not reach the queue");

    // a held result keeps the queue from draining
    a_stall_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("queue popped while result stalled");

    // never pop an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
